[src/dcs_pkg.sv]
// dcs_pkg: shared types and constants for the divisor count / sum classifier.
// No dependencies; imported by the interfaces, the arithmetic unit and the top level.
`timescale 1ns / 1ps
`default_nettype none
package dcs_pkg;

	localparam int NUM_WIDTH_DEF = 32;   // default active input width
	localparam int N_VALUE_W     = 32;   // input field width
	localparam int COUNT_W       = 11;   // divisor count field width
	localparam int SUM_OUT_W     = 35;   // divisor sum field width

	localparam int FIRST_ODD     = 3;    // first odd trial divisor
	localparam int ODD_STEP      = 2;    // trial divisor increment

	typedef enum logic {
		ALU_MUL,
		ALU_DIV
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic done;
	} alu_rsp_t;

endpackage
`default_nettype wire

[src/dcs_if.sv]
// dcs_if: valid/ready channel interfaces for the classifier's input and result beats.
// Depends on dcs_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface dcs_in_if;
	logic                          valid;
	logic                          ready;
	logic [dcs_pkg::N_VALUE_W-1:0] n_value;

	modport source (output valid, output n_value, input ready);
	modport sink   (input valid, input n_value, output ready);
endinterface

interface dcs_out_if;
	logic                          valid;
	logic                          ready;
	logic [dcs_pkg::COUNT_W-1:0]   divisor_count_out;
	logic [dcs_pkg::SUM_OUT_W-1:0] divisor_sum_out;
	logic                          is_arithmetic;
	logic                          is_composite_arithmetic;

	modport source (output valid, output divisor_count_out, output divisor_sum_out,
		output is_arithmetic, output is_composite_arithmetic, input ready);
	modport sink   (input valid, input divisor_count_out, input divisor_sum_out,
		input is_arithmetic, input is_composite_arithmetic, output ready);
endinterface
`default_nettype wire

[src/dcs_alu.sv]
// dcs_alu: shared bit-serial unit, shift-add multiply or restoring divide.
// Depends on dcs_pkg (alu_op_t, alu_req_t, alu_rsp_t).
`timescale 1ns / 1ps
`default_nettype none
module dcs_alu #(
	parameter int W = dcs_pkg::NUM_WIDTH_DEF + 3
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  dcs_pkg::alu_req_t     req,
	input  wire  [W-1:0]          a,
	input  wire  [W-1:0]          b,
	output dcs_pkg::alu_rsp_t     rsp,
	output logic [W-1:0]          result,
	output logic [W-1:0]          remainder
);
	import dcs_pkg::*;

	localparam int IDX_W = (W > 1) ? $clog2(W) : 1;

	logic             busy_q;
	logic             done_q;
	alu_op_t          op_q;
	logic [IDX_W-1:0] idx_q;
	logic [W-1:0]     a_q;       // multiplicand (shifted) / dividend (shifted, becomes quotient)
	logic [W-1:0]     b_q;       // multiplier (shifted) / divisor
	logic [W-1:0]     acc_q;     // product
	logic [W-1:0]     rem_q;     // partial remainder, always below the divisor

	logic [W:0]       trial;
	logic             fits;

	assign trial = {rem_q, a_q[W-1]};
	assign fits  = trial >= {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
			op_q   <= ALU_MUL;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				idx_q  <= '0;
				a_q    <= a;
				b_q    <= b;
				acc_q  <= '0;
				rem_q  <= '0;
			end else if (busy_q) begin
				unique case (op_q)
					ALU_MUL: begin
						if (b_q[0])
							acc_q <= acc_q + a_q;
						a_q <= {a_q[W-2:0], 1'b0};
						b_q <= {1'b0, b_q[W-1:1]};
					end
					ALU_DIV: begin
						// no fit means trial < divisor, so its top bit is clear
						rem_q <= fits ? W'(trial - {1'b0, b_q}) : trial[W-1:0];
						a_q   <= {a_q[W-2:0], fits};
					end
					default: ;
				endcase
				idx_q <= idx_q + 1'b1;
				if (idx_q == IDX_W'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done  = done_q;
	assign result    = (op_q == ALU_MUL) ? acc_q : a_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

[src/divisor_count_sum_classifier_unit.sv]
// Sequence: an accepted number has its factors of two stripped, then each odd trial divisor
// is tested and divided in the shared unit, with a multiply or divide there for each factor,
// the leftover prime and the final sum check, before the result goes to the output register.
// Worst case is a prime near 2^NUM_WIDTH: about 2^(NUM_WIDTH/2-1) trial divisors, each a
// test and serial divide.
// Throughput: one number at a time; num.ready is high only in idle. The result beat waits in
// an output register while the next number is accepted and factored.
// Reset: arst_n asynchronous, active low; clears the sequencer and the result valid. No sweep.
`timescale 1ns / 1ps
`default_nettype none
module divisor_count_sum_classifier_unit #(
	parameter int NUM_WIDTH = dcs_pkg::NUM_WIDTH_DEF
) (
	input wire         clk,
	input wire         arst_n,
	dcs_in_if.sink     num,
	dcs_out_if.source  res
);
	import dcs_pkg::*;

	// Internal widths follow the active input width.
	localparam int SUM_W = NUM_WIDTH + 3;           // sigma(n) < 2^(NUM_WIDTH+3)
	localparam int D_W   = (NUM_WIDTH + 1) / 2 + 1; // trial divisor stays near sqrt
	localparam int DSQ_W = 2 * D_W;                 // trial divisor squared

	typedef enum logic [3:0] {
		ST_IDLE,      // waiting for a number
		ST_TWOS,      // strip factors of two, one per cycle
		ST_TEST,      // d*d <= m ?
		ST_DIV,       // m / d in the shared unit
		ST_MUL_S,     // s = s*d + 1 (Horner form of 1 + d + ... + d^k)
		ST_MUL_SUM,   // sum *= s
		ST_LEFT,      // leftover prime
		ST_MUL_LEFT,  // sum *= m + 1
		ST_FDIV,      // sum % cnt
		ST_FIN        // hand result to output register
	} state_t;

	state_t               state_q;
	logic [NUM_WIDTH-1:0] m_q;     // unfactored part
	logic [NUM_WIDTH-1:0] pw_q;    // current power of two
	logic [D_W-1:0]       d_q;     // odd trial divisor
	logic [DSQ_W-1:0]     dsq_q;   // d_q squared, kept incrementally
	logic [COUNT_W-1:0]   cnt_q;   // running divisor count
	logic [COUNT_W-1:0]   c_q;     // exponent + 1 of current divisor
	logic [SUM_W-1:0]     sum_q;   // running divisor sum
	logic [SUM_W-1:0]     s_q;     // 1 + d + ... + d^k for current divisor
	logic                 arith_q;

	// shared unit
	alu_req_t             alu_req_q;
	logic [SUM_W-1:0]     alu_a_q;
	logic [SUM_W-1:0]     alu_b_q;
	alu_rsp_t             alu_rsp;
	logic [SUM_W-1:0]     alu_res;
	logic [SUM_W-1:0]     alu_rem;

	// output register
	logic                 out_valid_q;
	logic [COUNT_W-1:0]   out_cnt_q;
	logic [SUM_OUT_W-1:0] out_sum_q;
	logic                 out_arith_q;
	logic                 out_comp_q;

	logic [NUM_WIDTH-1:0] n_masked;
	logic [DSQ_W-1:0]     dsq_next;
	logic                 out_free;

	assign n_masked = num.n_value[NUM_WIDTH-1:0];
	// (d+2)^2 = d^2 + 4d + 4
	assign dsq_next = dsq_q + DSQ_W'({d_q, 2'b00}) + DSQ_W'(4);
	assign out_free = !out_valid_q || res.ready;

	dcs_alu #(.W(SUM_W)) u_alu (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (alu_req_q),
		.a         (alu_a_q),
		.b         (alu_b_q),
		.rsp       (alu_rsp),
		.result    (alu_res),
		.remainder (alu_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			alu_req_q   <= '{start: 1'b0, op: ALU_MUL};
		end else begin
			alu_req_q.start <= 1'b0;
			if (res.valid && res.ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (num.valid) begin
						m_q   <= n_masked;
						cnt_q <= COUNT_W'(1);
						sum_q <= SUM_W'(1);
						pw_q  <= NUM_WIDTH'(2);
						if (n_masked == '0) begin
							// zero: all result fields zero
							cnt_q   <= '0;
							sum_q   <= '0;
							arith_q <= 1'b0;
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_TWOS;
						end
					end
				end
				ST_TWOS: begin
					if (!m_q[0]) begin
						cnt_q <= cnt_q + 1'b1;
						sum_q <= sum_q + SUM_W'(pw_q);
						pw_q  <= {pw_q[NUM_WIDTH-2:0], 1'b0};
						m_q   <= {1'b0, m_q[NUM_WIDTH-1:1]};
					end else begin
						d_q     <= D_W'(FIRST_ODD);
						dsq_q   <= DSQ_W'(FIRST_ODD * FIRST_ODD);
						state_q <= ST_TEST;
					end
				end
				ST_TEST: begin
					if (dsq_q <= DSQ_W'(m_q)) begin
						c_q       <= COUNT_W'(1);
						s_q       <= SUM_W'(1);
						alu_req_q <= '{start: 1'b1, op: ALU_DIV};
						alu_a_q   <= SUM_W'(m_q);
						alu_b_q   <= SUM_W'(d_q);
						state_q   <= ST_DIV;
					end else begin
						state_q <= ST_LEFT;
					end
				end
				ST_DIV: begin
					if (alu_rsp.done) begin
						if (alu_rem == '0) begin
							// d divides m: take it out, extend the power sum
							c_q       <= c_q + 1'b1;
							m_q       <= alu_res[NUM_WIDTH-1:0];
							alu_req_q <= '{start: 1'b1, op: ALU_MUL};
							alu_a_q   <= s_q;
							alu_b_q   <= SUM_W'(d_q);
							state_q   <= ST_MUL_S;
						end else begin
							cnt_q <= COUNT_W'(cnt_q * c_q);
							if (c_q != COUNT_W'(1)) begin
								alu_req_q <= '{start: 1'b1, op: ALU_MUL};
								alu_a_q   <= sum_q;
								alu_b_q   <= s_q;
								state_q   <= ST_MUL_SUM;
							end else begin
								// d not a factor: s is 1, skip the multiply
								d_q     <= d_q + D_W'(ODD_STEP);
								dsq_q   <= dsq_next;
								state_q <= ST_TEST;
							end
						end
					end
				end
				ST_MUL_S: begin
					if (alu_rsp.done) begin
						s_q       <= alu_res + 1'b1;
						alu_req_q <= '{start: 1'b1, op: ALU_DIV};
						alu_a_q   <= SUM_W'(m_q);
						alu_b_q   <= SUM_W'(d_q);
						state_q   <= ST_DIV;
					end
				end
				ST_MUL_SUM: begin
					if (alu_rsp.done) begin
						sum_q   <= alu_res;
						d_q     <= d_q + D_W'(ODD_STEP);
						dsq_q   <= dsq_next;
						state_q <= ST_TEST;
					end
				end
				ST_LEFT: begin
					if (m_q > NUM_WIDTH'(1)) begin
						cnt_q     <= {cnt_q[COUNT_W-2:0], 1'b0};
						alu_req_q <= '{start: 1'b1, op: ALU_MUL};
						alu_a_q   <= sum_q;
						alu_b_q   <= SUM_W'(m_q) + 1'b1;
						state_q   <= ST_MUL_LEFT;
					end else begin
						alu_req_q <= '{start: 1'b1, op: ALU_DIV};
						alu_a_q   <= sum_q;
						alu_b_q   <= SUM_W'(cnt_q);
						state_q   <= ST_FDIV;
					end
				end
				ST_MUL_LEFT: begin
					if (alu_rsp.done) begin
						sum_q     <= alu_res;
						alu_req_q <= '{start: 1'b1, op: ALU_DIV};
						alu_a_q   <= alu_res;
						alu_b_q   <= SUM_W'(cnt_q);
						state_q   <= ST_FDIV;
					end
				end
				ST_FDIV: begin
					if (alu_rsp.done) begin
						arith_q <= (alu_rem == '0);
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// wait for the previous result beat to leave
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_cnt_q   <= cnt_q;
						out_sum_q   <= SUM_OUT_W'(sum_q);
						out_arith_q <= arith_q;
						out_comp_q  <= arith_q && (cnt_q > COUNT_W'(2));
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign num.ready                   = (state_q == ST_IDLE);
	assign res.valid                   = out_valid_q;
	assign res.divisor_count_out       = out_cnt_q;
	assign res.divisor_sum_out         = out_sum_q;
	assign res.is_arithmetic           = out_arith_q;
	assign res.is_composite_arithmetic = out_comp_q;

endmodule
`default_nettype wire

[src/dcs_checker.sv]
// dcs_checker: port-level assertions for divisor_count_sum_classifier_unit, bound to it below.
// Depends on dcs_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
module dcs_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          in_valid,
	input wire                          in_ready,
	input wire                          out_valid,
	input wire                          out_ready,
	input wire [dcs_pkg::COUNT_W-1:0]   count,
	input wire [dcs_pkg::SUM_OUT_W-1:0] sum,
	input wire                          arith,
	input wire                          comp
);
	import dcs_pkg::*;

	// a number keeps the block busy for at least the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input ready right after an accepted beat");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(count) && $stable(sum)
			&& $stable(arith) && $stable(comp)))
		else $error("stalled result beat changed or dropped");

	a_comp_implies: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && comp) |-> (arith && (count > COUNT_W'(2))))
		else $error("composite-arithmetic flag without arithmetic and count > 2");

	// count of one only for the number one
	a_unity: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (count == COUNT_W'(1))) |-> ((sum == SUM_OUT_W'(1)) && arith && !comp))
		else $error("count of one with wrong sum or flags");

endmodule

bind divisor_count_sum_classifier_unit dcs_checker u_dcs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (num.valid),
	.in_ready  (num.ready),
	.out_valid (res.valid),
	.out_ready (res.ready),
	.count     (res.divisor_count_out),
	.sum       (res.divisor_sum_out),
	.arith     (res.is_arithmetic),
	.comp      (res.is_composite_arithmetic)
);
`default_nettype wire

[test/dcs_result_checker.sv]
// dcs_result_checker: watches the number and result channels of the classifier, predicts
// every result beat and compares it field by field. Depends on dcs_pkg and dcs_if.
`timescale 1ns / 1ps
module dcs_result_checker #(
	parameter int NUM_WIDTH = dcs_pkg::NUM_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	dcs_in_if    num,
	dcs_out_if   res,
	output int   mismatch_count,
	output int   outstanding
);
	import dcs_pkg::*;

	typedef struct packed {
		logic [N_VALUE_W-1:0] n_value;
		logic [COUNT_W-1:0]   count;
		logic [SUM_OUT_W-1:0] sum;
		logic                 arith;
		logic                 comp_arith;
	} divisor_stats_t;

	divisor_stats_t expected_stats[$];
	int             fail_total    = 0;
	int             pending_total = 0;

	assign mismatch_count = fail_total;
	assign outstanding    = pending_total;

	// trial division: twos first, then odd divisors up to the root of what is left
	function automatic divisor_stats_t classify_number(logic [N_VALUE_W-1:0] n);
		longint unsigned m, cnt, sum, pw, d, c, s;
		divisor_stats_t  r;
		r         = '0;
		r.n_value = n;
		m         = n;
		m         = m & ((64'd1 << NUM_WIDTH) - 64'd1);
		if (m == 0) begin
			return r;
		end
		cnt = 1;
		sum = 1;
		pw  = 2;
		while ((m & 64'd1) == 0) begin
			cnt += 1;
			sum += pw;
			pw  = pw << 1;
			m   = m >> 1;
		end
		for (d = FIRST_ODD; d * d <= m; d += ODD_STEP) begin
			c  = 1;
			s  = 1;
			pw = d;
			while (m % d == 0) begin
				c  += 1;
				s  += pw;
				pw *= d;
				m  /= d;
			end
			cnt *= c;
			sum *= s;
		end
		if (m > 1) begin
			cnt *= 2;
			sum *= m + 1;
		end
		r.count      = cnt[COUNT_W-1:0];
		r.sum        = sum[SUM_OUT_W-1:0];
		r.arith      = (sum % cnt) == 0;
		r.comp_arith = r.arith && (cnt > 2);
		return r;
	endfunction

	task automatic report_failure(input string msg);
		$display("[%0t] MISMATCH %s", $time, msg);
		fail_total++;
	endtask

	// result side first: a beat leaving now belongs to an earlier number
	always @(posedge clk) begin
		divisor_stats_t want;
		if (arst_n) begin
			if (res.valid && res.ready) begin
				if (expected_stats.size() == 0) begin
					report_failure($sformatf("result beat with nothing pending: count %0d sum %0d",
						res.divisor_count_out, res.divisor_sum_out));
				end else begin
					want = expected_stats.pop_front();
					if (res.divisor_count_out !== want.count)
						report_failure($sformatf("n=%0d divisor count %0d, expected %0d",
							want.n_value, res.divisor_count_out, want.count));
					if (res.divisor_sum_out !== want.sum)
						report_failure($sformatf("n=%0d divisor sum %0d, expected %0d",
							want.n_value, res.divisor_sum_out, want.sum));
					if (res.is_arithmetic !== want.arith)
						report_failure($sformatf("n=%0d arithmetic flag %0b, expected %0b",
							want.n_value, res.is_arithmetic, want.arith));
					if (res.is_composite_arithmetic !== want.comp_arith)
						report_failure($sformatf("n=%0d composite flag %0b, expected %0b",
							want.n_value, res.is_composite_arithmetic, want.comp_arith));
				end
			end
			if (num.valid && num.ready) begin
				expected_stats.push_back(classify_number(num.n_value));
			end
			pending_total = expected_stats.size();
		end
	end

endmodule

[test/testbench.sv]
// testbench: top of the divisor count / sum classifier test. Drives numbers in bursts,
// stalls the result side, and gives the verdict. Depends on dcs_pkg, dcs_if, the block
// and dcs_result_checker.
`timescale 1ns / 1ps
module testbench;
	import dcs_pkg::*;

	localparam int RESET_CYCLES       = 12;
	localparam int RANDOM_ITEMS       = 100;
	// receiver holds: the first starts right out of reset, the second after some beats
	localparam int FIRST_HOLD_CYCLES  = 3000;
	localparam int SECOND_HOLD_AFTER  = 40;
	localparam int SECOND_HOLD_CYCLES = 6000;
	localparam int DRAIN_CYCLES       = 200;
	// watchdog limit, far above the slowest item
	localparam longint RUN_LIMIT_NS   = 40_000_000;

	// Corner numbers. Every one of them factors quickly; primes near 2^32 would need about
	// 2^15 odd trial divisors each and are left out on purpose.
	localparam int CORNER_COUNT = 21;
	localparam logic [N_VALUE_W-1:0] CORNER_NUMBERS [CORNER_COUNT] = '{
		32'd0,            // no divisor set: all fields zero
		32'd1,            // unity: count 1, sum 1
		32'd2,            // prime, not arithmetic
		32'd3,            // prime, arithmetic but not composite
		32'd4,
		32'd6,            // composite arithmetic
		32'd8,            // pure power of two, not arithmetic
		32'd9,
		32'd12,
		32'd30,
		32'd49,           // square of an odd prime
		32'd63001,        // 251^2: divisor squared lands exactly on the remainder
		32'd65537,        // prime leftover after the odd loop runs out
		32'd1048573,      // largest prime below 2^20, long odd loop
		32'h8000_0000,    // all twos
		32'hFFFF_FFFF,    // all ones, sum well past 32 bits
		32'hFFFF_FF00,
		32'h5555_5555,
		32'hAAAA_AAAA,
		32'd3486784401,   // 3^20
		32'd3491888400    // highly composite, largest count in range
	};

	localparam int PRIME_COUNT = 25;
	localparam int unsigned SMALL_PRIMES [PRIME_COUNT] = '{
		2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47,
		53, 59, 61, 67, 71, 73, 79, 83, 89, 97
	};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	int   mismatch_count;
	int   outstanding;

	dcs_in_if  num_ch ();
	dcs_out_if res_ch ();

	always #1 clk = ~clk;

	divisor_count_sum_classifier_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num_ch),
		.res    (res_ch)
	);

	dcs_result_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.num            (num_ch),
		.res            (res_ch),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	// Random numbers are kept cheap to factor: the largest prime factor left for the
	// odd loop stays below 2^16. Smooth products of small primes reach the top bits
	// of the field.
	function automatic logic [N_VALUE_W-1:0] random_number();
		longint unsigned n;
		longint unsigned p;
		int              steps;
		case ($urandom_range(0, 9))
			0: n = $urandom_range(1, 4095);
			1: n = $urandom_range(1, 65535);
			2: n = 64'($urandom_range(1, 65535)) << $urandom_range(1, 16);
			default: begin
				n     = $urandom_range(1, 1023);
				steps = $urandom_range(1, 30);
				repeat (steps) begin
					p = SMALL_PRIMES[$urandom_range(0, PRIME_COUNT - 1)];
					if (n * p <= 64'hFFFF_FFFF) begin
						n *= p;
					end
				end
			end
		endcase
		return n[N_VALUE_W-1:0];
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat is taken,
	// with valid still high so a back-to-back beat needs no second assignment.
	task automatic offer_number(input logic [N_VALUE_W-1:0] n);
		num_ch.valid   <= 1'b1;
		num_ch.n_value <= n;
		do @(posedge clk); while (!num_ch.ready);
		@(negedge clk);
	endtask

	// Idle gap between bursts; junk on the data lines while valid is low.
	task automatic pause_sender(input int cycles);
		num_ch.valid   <= 1'b0;
		num_ch.n_value <= $urandom;
		repeat (cycles) @(negedge clk);
	endtask

	// Number side: corners back to back, then random bursts.
	initial begin
		int sent;
		int burst_left;
		int gap;
		num_ch.valid   = 1'b0;
		num_ch.n_value = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < CORNER_COUNT; i++) begin
			offer_number(CORNER_NUMBERS[i]);
		end

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst_left = $urandom_range(1, 8);
			while (burst_left > 0 && sent < RANDOM_ITEMS) begin
				offer_number(random_number());
				burst_left--;
				sent++;
			end
			// about a quarter of bursts run straight into the next one
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			if (gap > 0) begin
				pause_sender(gap);
			end
		end
		if (gap == 0) begin
			num_ch.valid <= 1'b0;
		end

		// drain: every prediction answered, then a quiet stretch to catch strays
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Result side. Held off right out of reset so the output register fills and the
	// block stops taking numbers; held off again later in the run. In between, ready
	// follows a 16-bit pattern, reloaded whenever the slot counter wraps: always ready,
	// random, mostly ready or mostly stalled.
	initial begin
		int          beats;
		int          slot;
		bit          second_hold_done;
		logic [15:0] stall_pattern;
		res_ch.ready = 1'b0;
		beats            = 0;
		slot             = 0;
		second_hold_done = 1'b0;
		stall_pattern    = '1;
		wait (arst_n);
		repeat (FIRST_HOLD_CYCLES) @(negedge clk);
		forever begin
			if (!second_hold_done && beats >= SECOND_HOLD_AFTER) begin
				res_ch.ready <= 1'b0;
				repeat (SECOND_HOLD_CYCLES) @(negedge clk);
				second_hold_done = 1'b1;
			end
			if (slot == 0) begin
				case ($urandom_range(0, 3))
					0: stall_pattern = '1;
					1: stall_pattern = $urandom;
					2: stall_pattern = $urandom | $urandom;
					default: stall_pattern = $urandom & $urandom;
				endcase
			end
			res_ch.ready <= stall_pattern[slot % 16];
			slot = (slot + 1) % 64;
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				beats++;
			end
			@(negedge clk);
		end
	end

	// Watchdog.
	initial begin
		#(RUN_LIMIT_NS);
		$display("Verification failed");
		$finish;
	end

endmodule
